### hdl/vrot_pkg.sv
package vrot_pkg;

	localparam int COORD_WIDTH_DEF  = 32;
	localparam int ANGLE_WIDTH_DEF  = 16;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int QUEUE_DEPTH      = 4;

	// Fraction bits added below the Q16.16 point while the vector turns.
	localparam int GUARD_BITS = 12;
	// The angle accumulator counts 2^TURN_BITS units per turn.
	localparam int TURN_BITS  = 32;
	localparam int ACC_WIDTH  = TURN_BITS + 1;
	localparam int GAIN_WIDTH = 31;
	localparam int GAIN_SHIFT = 30;
	localparam logic signed [GAIN_WIDTH-1:0] GAIN_Q30 = 31'sd652032874;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef enum logic [1:0] {
		ROUTE_XY,
		ROUTE_YZ,
		ROUTE_ZX,
		ROUTE_NONE
	} route_t;

	typedef struct packed {
		route_t route;
		logic   bypass;
	} ctl_t;

	function automatic logic [31:0] atan_entry(input logic [4:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0:    v = 32'd536870912;
			5'd1:    v = 32'd316933406;
			5'd2:    v = 32'd167458907;
			5'd3:    v = 32'd85004756;
			5'd4:    v = 32'd42667331;
			5'd5:    v = 32'd21354465;
			5'd6:    v = 32'd10679838;
			5'd7:    v = 32'd5340245;
			5'd8:    v = 32'd2670163;
			5'd9:    v = 32'd1335087;
			5'd10:   v = 32'd667544;
			5'd11:   v = 32'd333772;
			5'd12:   v = 32'd166886;
			5'd13:   v = 32'd83443;
			5'd14:   v = 32'd41722;
			5'd15:   v = 32'd20861;
			5'd16:   v = 32'd10430;
			5'd17:   v = 32'd5215;
			5'd18:   v = 32'd2608;
			5'd19:   v = 32'd1304;
			5'd20:   v = 32'd652;
			5'd21:   v = 32'd326;
			5'd22:   v = 32'd163;
			5'd23:   v = 32'd81;
			5'd24:   v = 32'd41;
			5'd25:   v = 32'd20;
			5'd26:   v = 32'd10;
			5'd27:   v = 32'd5;
			5'd28:   v = 32'd3;
			5'd29:   v = 32'd1;
			5'd30:   v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

### hdl/vrot_front.sv
module vrot_front #(
	parameter int COORD_WIDTH = vrot_pkg::COORD_WIDTH_DEF,
	parameter int ANGLE_WIDTH = vrot_pkg::ANGLE_WIDTH_DEF
) (
	input  logic signed [COORD_WIDTH-1:0] x_in,
	input  logic signed [COORD_WIDTH-1:0] y_in,
	input  logic signed [COORD_WIDTH-1:0] z_in,
	input  logic        [ANGLE_WIDTH-1:0] angle,
	input  logic        [1:0]             axis,
	input  logic                          three_d,
	output logic signed [COORD_WIDTH:0]   a,
	output logic signed [COORD_WIDTH:0]   b,
	output logic        [COORD_WIDTH-1:0] pass,
	output logic        [ANGLE_WIDTH-3:0] resid,
	output vrot_pkg::ctl_t                ctl
);

	localparam logic [1:0] QUAD_90  = 2'd1;
	localparam logic [1:0] QUAD_180 = 2'd2;
	localparam logic [1:0] QUAD_270 = 2'd3;

	logic signed [COORD_WIDTH-1:0] src_a;
	logic signed [COORD_WIDTH-1:0] src_b;
	logic signed [COORD_WIDTH:0]   ext_a;
	logic signed [COORD_WIDTH:0]   ext_b;
	logic        [1:0]             quad;

	always_comb begin
		src_a = x_in;
		src_b = y_in;
		pass = z_in;
		ctl.route = vrot_pkg::ROUTE_XY;
		if (!three_d) begin
			pass = '0;
		end else begin
			case (axis)
				vrot_pkg::AXIS_X: begin
					src_a = y_in;
					src_b = z_in;
					pass = x_in;
					ctl.route = vrot_pkg::ROUTE_YZ;
				end
				vrot_pkg::AXIS_Y: begin
					src_a = z_in;
					src_b = x_in;
					pass = y_in;
					ctl.route = vrot_pkg::ROUTE_ZX;
				end
				vrot_pkg::AXIS_Z: begin
					ctl.route = vrot_pkg::ROUTE_XY;
				end
				default: begin
					ctl.route = vrot_pkg::ROUTE_NONE;
				end
			endcase
		end
		ctl.bypass = (ctl.route == vrot_pkg::ROUTE_NONE);
	end

	assign ext_a = {src_a[COORD_WIDTH-1], src_a};
	assign ext_b = {src_b[COORD_WIDTH-1], src_b};
	assign quad = angle[ANGLE_WIDTH-1:ANGLE_WIDTH-2];
	assign resid = angle[ANGLE_WIDTH-3:0];

	// Exact quarter-turn pre-rotation; the CORDIC stages cover the rest.
	always_comb begin
		a = ext_a;
		b = ext_b;
		if (!ctl.bypass) begin
			case (quad)
				QUAD_90: begin
					a = -ext_b;
					b = ext_a;
				end
				QUAD_180: begin
					a = -ext_a;
					b = -ext_b;
				end
				QUAD_270: begin
					a = ext_b;
					b = -ext_a;
				end
				default: begin
					a = ext_a;
					b = ext_b;
				end
			endcase
		end
	end

endmodule

### hdl/vrot_queue.sv
module vrot_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = vrot_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             not_empty
);

	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam logic [ADDR_W-1:0] LAST = ADDR_W'(DEPTH - 1);

	logic [WIDTH-1:0]  mem_q [DEPTH];
	logic [ADDR_W-1:0] wr_ptr_q;
	logic [ADDR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + ADDR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + ADDR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> not_empty && !(push && full))
		else $error("queue popped while empty or pushed while full");
	assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("queue count did not follow a lone push");

endmodule

### hdl/vrot_back.sv
module vrot_back #(
	parameter int COORD_WIDTH  = vrot_pkg::COORD_WIDTH_DEF,
	parameter int ANGLE_WIDTH  = vrot_pkg::ANGLE_WIDTH_DEF,
	parameter int CORDIC_STEPS = vrot_pkg::CORDIC_STEPS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic signed [COORD_WIDTH:0]   in_a,
	input  logic signed [COORD_WIDTH:0]   in_b,
	input  logic        [COORD_WIDTH-1:0] in_pass,
	input  logic        [ANGLE_WIDTH-3:0] in_resid,
	input  vrot_pkg::ctl_t                in_ctl,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic        [COORD_WIDTH-1:0] x_out,
	output logic        [COORD_WIDTH-1:0] y_out,
	output logic        [COORD_WIDTH-1:0] z_out
);

	localparam int G   = vrot_pkg::GUARD_BITS;
	localparam int W   = COORD_WIDTH + G + 3;
	localparam int ZW  = vrot_pkg::ACC_WIDTH;
	localparam int ZSH = vrot_pkg::TURN_BITS - ANGLE_WIDTH;
	localparam int LO  = W / 2;
	localparam int HI  = W - LO;
	localparam int GW  = vrot_pkg::GAIN_WIDTH;
	localparam int ML  = LO + GW + 1;
	localparam int MH  = HI + GW;
	localparam int PW  = W + GW;
	localparam int SH  = vrot_pkg::GAIN_SHIFT + G;
	localparam int RW  = PW - SH;
	localparam logic signed [PW-1:0] ROUND = {{(PW-SH){1'b0}}, 1'b1, {(SH-1){1'b0}}};
	localparam logic signed [RW-1:0] MAXV = {{(RW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [RW-1:0] MINV = {{(RW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

	logic                          adv;
	logic signed [W-1:0]           a0;
	logic signed [W-1:0]           b0;
	logic signed [ZW-1:0]          z0;

	logic        [CORDIC_STEPS-1:0] cv_s;
	logic signed [W-1:0]            ca_s [CORDIC_STEPS];
	logic signed [W-1:0]            cb_s [CORDIC_STEPS];
	logic signed [ZW-1:0]           cz_s [CORDIC_STEPS];
	logic        [COORD_WIDTH-1:0]  cp_s [CORDIC_STEPS];
	vrot_pkg::ctl_t                 cc_s [CORDIC_STEPS];

	logic                          mul_v_s;
	logic signed [LO+GW:0]         mul_alo_s;
	logic signed [HI+GW-1:0]       mul_ahi_s;
	logic signed [LO+GW:0]         mul_blo_s;
	logic signed [HI+GW-1:0]       mul_bhi_s;
	logic        [COORD_WIDTH-1:0] mul_rawa_s;
	logic        [COORD_WIDTH-1:0] mul_rawb_s;
	logic        [COORD_WIDTH-1:0] mul_pass_s;
	vrot_pkg::ctl_t                mul_ctl_s;

	logic                          sum_v_s;
	logic signed [PW-1:0]          sum_a_s;
	logic signed [PW-1:0]          sum_b_s;
	logic        [COORD_WIDTH-1:0] sum_rawa_s;
	logic        [COORD_WIDTH-1:0] sum_rawb_s;
	logic        [COORD_WIDTH-1:0] sum_pass_s;
	vrot_pkg::ctl_t                sum_ctl_s;

	logic                          out_valid_q;
	logic        [COORD_WIDTH-1:0] x_q;
	logic        [COORD_WIDTH-1:0] y_q;
	logic        [COORD_WIDTH-1:0] z_q;
	logic        [COORD_WIDTH-1:0] sat_a;
	logic        [COORD_WIDTH-1:0] sat_b;

	function automatic logic [COORD_WIDTH-1:0] saturate(input logic signed [RW-1:0] r);
		logic [COORD_WIDTH-1:0] v;
		if (r > MAXV) begin
			v = MAXV[COORD_WIDTH-1:0];
		end else if (r < MINV) begin
			v = MINV[COORD_WIDTH-1:0];
		end else begin
			v = r[COORD_WIDTH-1:0];
		end
		return v;
	endfunction

	// The whole pipeline moves together whenever the output register can take a result.
	assign adv = !out_valid_q || out_ready;
	assign pop = adv && in_valid;

	assign a0 = {{(W-COORD_WIDTH-1-G){in_a[COORD_WIDTH]}}, in_a, {G{1'b0}}};
	assign b0 = {{(W-COORD_WIDTH-1-G){in_b[COORD_WIDTH]}}, in_b, {G{1'b0}}};
	assign z0 = {{(ZW-ANGLE_WIDTH+2-ZSH){1'b0}}, in_resid, {ZSH{1'b0}}};

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic                          v_in;
		logic signed [W-1:0]           a_in;
		logic signed [W-1:0]           b_in;
		logic signed [ZW-1:0]          z_in;
		logic        [COORD_WIDTH-1:0] p_in;
		vrot_pkg::ctl_t                c_in;
		logic signed [W-1:0]           da;
		logic signed [W-1:0]           db;
		logic signed [ZW-1:0]          at;
		logic                          up;

		if (i == 0) begin : g_first
			assign v_in = in_valid;
			assign a_in = a0;
			assign b_in = b0;
			assign z_in = z0;
			assign p_in = in_pass;
			assign c_in = in_ctl;
		end else begin : g_next
			assign v_in = cv_s[i-1];
			assign a_in = ca_s[i-1];
			assign b_in = cb_s[i-1];
			assign z_in = cz_s[i-1];
			assign p_in = cp_s[i-1];
			assign c_in = cc_s[i-1];
		end

		assign da = b_in >>> i;
		assign db = a_in >>> i;
		assign at = {{(ZW-32){1'b0}}, vrot_pkg::atan_entry(5'(i))};
		assign up = !z_in[ZW-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s[i] <= 1'b0;
			end else if (adv) begin
				cv_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				cp_s[i] <= p_in;
				cc_s[i] <= c_in;
				if (c_in.bypass) begin
					ca_s[i] <= a_in;
					cb_s[i] <= b_in;
					cz_s[i] <= z_in;
				end else if (up) begin
					ca_s[i] <= a_in - da;
					cb_s[i] <= b_in + db;
					cz_s[i] <= z_in - at;
				end else begin
					ca_s[i] <= a_in + da;
					cb_s[i] <= b_in - db;
					cz_s[i] <= z_in + at;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_v_s <= 1'b0;
			sum_v_s <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			mul_v_s <= cv_s[CORDIC_STEPS-1];
			sum_v_s <= mul_v_s;
			out_valid_q <= sum_v_s;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mul_alo_s <= ML'($signed({1'b0, ca_s[CORDIC_STEPS-1][LO-1:0]}))
				* ML'(vrot_pkg::GAIN_Q30);
			mul_ahi_s <= MH'($signed(ca_s[CORDIC_STEPS-1][W-1:LO])) * MH'(vrot_pkg::GAIN_Q30);
			mul_blo_s <= ML'($signed({1'b0, cb_s[CORDIC_STEPS-1][LO-1:0]}))
				* ML'(vrot_pkg::GAIN_Q30);
			mul_bhi_s <= MH'($signed(cb_s[CORDIC_STEPS-1][W-1:LO])) * MH'(vrot_pkg::GAIN_Q30);
			mul_rawa_s <= ca_s[CORDIC_STEPS-1][COORD_WIDTH+G-1:G];
			mul_rawb_s <= cb_s[CORDIC_STEPS-1][COORD_WIDTH+G-1:G];
			mul_pass_s <= cp_s[CORDIC_STEPS-1];
			mul_ctl_s <= cc_s[CORDIC_STEPS-1];

			sum_a_s <= $signed({mul_ahi_s, {LO{1'b0}}}) + PW'(mul_alo_s) + ROUND;
			sum_b_s <= $signed({mul_bhi_s, {LO{1'b0}}}) + PW'(mul_blo_s) + ROUND;
			sum_rawa_s <= mul_rawa_s;
			sum_rawb_s <= mul_rawb_s;
			sum_pass_s <= mul_pass_s;
			sum_ctl_s <= mul_ctl_s;
		end
	end

	assign sat_a = saturate(sum_a_s[PW-1:SH]);
	assign sat_b = saturate(sum_b_s[PW-1:SH]);

	always_ff @(posedge clk) begin
		if (adv) begin
			case (sum_ctl_s.route)
				vrot_pkg::ROUTE_XY: begin
					x_q <= sat_a;
					y_q <= sat_b;
					z_q <= sum_pass_s;
				end
				vrot_pkg::ROUTE_YZ: begin
					x_q <= sum_pass_s;
					y_q <= sat_a;
					z_q <= sat_b;
				end
				vrot_pkg::ROUTE_ZX: begin
					x_q <= sat_b;
					y_q <= sum_pass_s;
					z_q <= sat_a;
				end
				default: begin
					x_q <= sum_rawa_s;
					y_q <= sum_rawb_s;
					z_q <= sum_pass_s;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign x_out = x_q;
	assign y_out = y_q;
	assign z_out = z_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(cv_s) && $stable(mul_v_s) && $stable(sum_v_s))
		else $error("pipeline moved while the output was stalled");

endmodule

### hdl/vector_axis_rotation.sv
// Rotates a 2D or 3D Q16.16 vector by a binary angle (2^ANGLE_WIDTH units per
// turn) with an unrolled CORDIC pipeline, one stage per iteration, followed by
// a two-stage gain correction and a saturating output register. A 2D vector
// turns in its plane and z_out is zero; a 3D vector turns about X, Y or Z and
// the coordinate on that axis passes through exactly; axis code 3 passes all
// three coordinates through. The block takes one request per clock cycle in
// steady state while the output is not stalled. A request passes from the input
// queue through the CORDIC stages, the multiply and sum stages of the gain
// correction and the output register. A four-entry queue behind the input lets
// requests keep arriving while the output is stalled.
module vector_axis_rotation #(
	parameter int COORD_WIDTH  = vrot_pkg::COORD_WIDTH_DEF,
	parameter int ANGLE_WIDTH  = vrot_pkg::ANGLE_WIDTH_DEF,
	parameter int CORDIC_STEPS = vrot_pkg::CORDIC_STEPS_DEF,
	localparam int IN_W  = ((3 * COORD_WIDTH + ANGLE_WIDTH + 7) / 8) * 8,
	localparam int OUT_W = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,  // x_in, y_in, z_in, angle, zero padding
	input  logic [2:0]       s_axis_tuser,  // axis, three_d
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata   // x_out, y_out, z_out, zero padding
);

	localparam int QW = 3 * COORD_WIDTH + 2 + ANGLE_WIDTH - 2 + $bits(vrot_pkg::ctl_t);

	logic signed [COORD_WIDTH-1:0] x_in;
	logic signed [COORD_WIDTH-1:0] y_in;
	logic signed [COORD_WIDTH-1:0] z_in;
	logic        [ANGLE_WIDTH-1:0] angle;
	logic        [1:0]             axis;
	logic                          three_d;

	logic signed [COORD_WIDTH:0]   f_a;
	logic signed [COORD_WIDTH:0]   f_b;
	logic        [COORD_WIDTH-1:0] f_pass;
	logic        [ANGLE_WIDTH-3:0] f_resid;
	vrot_pkg::ctl_t                f_ctl;

	logic                          q_full;
	logic                          q_push;
	logic                          q_pop;
	logic                          q_valid;
	logic        [QW-1:0]          q_data;

	logic signed [COORD_WIDTH:0]   b_a;
	logic signed [COORD_WIDTH:0]   b_b;
	logic        [COORD_WIDTH-1:0] b_pass;
	logic        [ANGLE_WIDTH-3:0] b_resid;
	vrot_pkg::ctl_t                b_ctl;

	logic        [COORD_WIDTH-1:0] x_out;
	logic        [COORD_WIDTH-1:0] y_out;
	logic        [COORD_WIDTH-1:0] z_out;

	assign x_in = s_axis_tdata[COORD_WIDTH-1:0];
	assign y_in = s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
	assign z_in = s_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
	assign angle = s_axis_tdata[3*COORD_WIDTH+ANGLE_WIDTH-1:3*COORD_WIDTH];
	assign axis = s_axis_tuser[1:0];
	assign three_d = s_axis_tuser[2];

	vrot_front #(
		.COORD_WIDTH(COORD_WIDTH),
		.ANGLE_WIDTH(ANGLE_WIDTH)
	) u_front (
		.x_in   (x_in),
		.y_in   (y_in),
		.z_in   (z_in),
		.angle  (angle),
		.axis   (axis),
		.three_d(three_d),
		.a      (f_a),
		.b      (f_b),
		.pass   (f_pass),
		.resid  (f_resid),
		.ctl    (f_ctl)
	);

	assign s_axis_tready = !q_full;
	assign q_push = s_axis_tvalid && !q_full;

	vrot_queue #(
		.WIDTH(QW),
		.DEPTH(vrot_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data({f_ctl, f_resid, f_pass, f_b, f_a}),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (q_data),
		.not_empty(q_valid)
	);

	assign {b_ctl, b_resid, b_pass, b_b, b_a} = q_data;

	vrot_back #(
		.COORD_WIDTH (COORD_WIDTH),
		.ANGLE_WIDTH (ANGLE_WIDTH),
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_valid),
		.in_a     (b_a),
		.in_b     (b_b),
		.in_pass  (b_pass),
		.in_resid (b_resid),
		.in_ctl   (b_ctl),
		.pop      (q_pop),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.x_out    (x_out),
		.y_out    (y_out),
		.z_out    (z_out)
	);

	assign m_axis_tdata = OUT_W'({z_out, y_out, x_out});

endmodule

### tb/sv/vector_axis_rotation_tb.sv
`timescale 1ns / 1ps

module vector_axis_rotation_tb;

	localparam logic [1:0]  AXIS_X     = vrot_pkg::AXIS_X;
	localparam logic [1:0]  AXIS_Y     = vrot_pkg::AXIS_Y;
	localparam logic [1:0]  AXIS_Z     = vrot_pkg::AXIS_Z;
	localparam logic [1:0]  AXIS_NONE  = 2'd3;
	localparam logic [31:0] MAXC       = 32'h7fffffff;
	localparam logic [31:0] MINC       = 32'h80000000;
	localparam logic [31:0] ONE        = 32'h00010000;
	localparam int          GUARD      = 12;
	localparam longint      GAIN       = 64'sd652032874;
	localparam int          STEPS      = 16;
	localparam int          RAND_ITEMS = 750;
	localparam int          LIMIT      = 200000;
	localparam int          HOLD_LEN   = 300;
	localparam int          DRAIN      = 40;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [15:0] angle;
		logic [1:0]  axis;
		logic        three_d;
	} rot_req_t;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
	} rot_res_t;

	typedef struct packed {
		logic     known;
		rot_res_t res;
	} preset_t;

	typedef struct packed {
		rot_req_t req;
		logic     known;
		rot_res_t res;
	} row_t;

	localparam row_t DIRECTED [18] = '{
		'{'{32'h0, 32'h0, 32'h0, 16'h0000, AXIS_X, 1'b0}, 1'b1, '{32'h0, 32'h0, 32'h0}},
		'{'{32'h0, 32'h0, 32'h0, 16'hffff, AXIS_X, 1'b1}, 1'b1, '{32'h0, 32'h0, 32'h0}},
		'{'{MAXC, MINC, 32'h12345678, 16'h2000, AXIS_NONE, 1'b1}, 1'b1,
			'{MAXC, MINC, 32'h12345678}},
		'{'{MINC, MAXC, 32'hffffffff, 16'hffff, AXIS_NONE, 1'b1}, 1'b1,
			'{MINC, MAXC, 32'hffffffff}},
		'{'{MAXC, 32'h0, 32'h0, 16'h0000, AXIS_X, 1'b0}, 1'b0, '0},
		'{'{MAXC, 32'h0, 32'h0, 16'h4000, AXIS_X, 1'b0}, 1'b0, '0},
		'{'{MAXC, 32'h0, 32'h0, 16'h8000, AXIS_X, 1'b0}, 1'b0, '0},
		'{'{MAXC, 32'h0, 32'h0, 16'hc000, AXIS_X, 1'b0}, 1'b0, '0},
		'{'{MINC, MINC, 32'h0, 16'h2000, AXIS_Y, 1'b0}, 1'b0, '0},
		'{'{MAXC, MAXC, 32'h0, 16'hffff, AXIS_Z, 1'b0}, 1'b0, '0},
		'{'{ONE, 2 * ONE, 3 * ONE, 16'h2000, AXIS_X, 1'b1}, 1'b0, '0},
		'{'{ONE, 2 * ONE, 3 * ONE, 16'h2000, AXIS_Y, 1'b1}, 1'b0, '0},
		'{'{ONE, 2 * ONE, 3 * ONE, 16'h2000, AXIS_Z, 1'b1}, 1'b0, '0},
		'{'{MAXC, 32'h0, MINC, 16'h6000, AXIS_Y, 1'b1}, 1'b0, '0},
		'{'{ONE, ONE, MAXC, 16'h1234, AXIS_NONE, 1'b0}, 1'b0, '0},
		'{'{32'h1, 32'hffffffff, 32'h0, 16'h0001, AXIS_Z, 1'b0}, 1'b0, '0},
		'{'{MINC, MINC, MAXC, 16'hc000, AXIS_Z, 1'b1}, 1'b0, '0},
		'{'{32'h0, MAXC, MAXC, 16'ha000, AXIS_X, 1'b1}, 1'b0, '0}
	};

	localparam longint ARCTAN [STEPS] = '{
		64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004756,
		64'sd42667331, 64'sd21354465, 64'sd10679838, 64'sd5340245,
		64'sd2670163, 64'sd1335087, 64'sd667544, 64'sd333772,
		64'sd166886, 64'sd83443, 64'sd41722, 64'sd20861
	};

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [111:0] s_axis_tdata;  // x_in, y_in, z_in, angle
	logic [2:0]   s_axis_tuser;  // axis, three_d
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [95:0]  m_axis_tdata;  // x_out, y_out, z_out

	rot_res_t rotated_q [$];
	preset_t  preset_q [$];
	int       mismatches = 0;
	int       cycles = 0;
	int       tx_idle = 0;
	int       rx_idle = 0;
	logic     hold_req = 1'b0;

	vector_axis_rotation i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] scale_round(longint v);
		logic signed [127:0] p;
		longint r;
		p = v;
		p = (p * GAIN) >>> 30;
		r = p[63:0];
		r = (r + (64'sd1 <<< (GUARD - 1))) >>> GUARD;
		if (r > 64'sd2147483647) begin
			return MAXC;
		end
		if (r < -64'sd2147483648) begin
			return MINC;
		end
		return r[31:0];
	endfunction

	function automatic void turn_pair(inout logic [31:0] pa, inout logic [31:0] pb,
		input logic [15:0] ang);
		longint a, b, t, da, db, acc;
		a = longint'(signed'(pa)) <<< GUARD;
		b = longint'(signed'(pb)) <<< GUARD;
		case (ang[15:14])
			2'd1: begin
				t = a;
				a = -b;
				b = t;
			end
			2'd2: begin
				a = -a;
				b = -b;
			end
			2'd3: begin
				t = a;
				a = b;
				b = -t;
			end
			default: ;
		endcase
		acc = longint'(ang[13:0]) <<< 16;
		for (int i = 0; i < STEPS; i++) begin
			da = b >>> i;
			db = a >>> i;
			if (acc >= 0) begin
				a = a - da;
				b = b + db;
				acc = acc - ARCTAN[i];
			end else begin
				a = a + da;
				b = b - db;
				acc = acc + ARCTAN[i];
			end
		end
		pa = scale_round(a);
		pb = scale_round(b);
	endfunction

	function automatic rot_res_t rotate_vector(rot_req_t q);
		rot_res_t r;
		r.x = q.x;
		r.y = q.y;
		r.z = q.z;
		if (!q.three_d) begin
			turn_pair(r.x, r.y, q.angle);
			r.z = '0;
		end else begin
			case (q.axis)
				AXIS_X: turn_pair(r.y, r.z, q.angle);
				AXIS_Y: turn_pair(r.z, r.x, q.angle);
				AXIS_Z: turn_pair(r.x, r.y, q.angle);
				default: ;
			endcase
		end
		return r;
	endfunction

	function automatic logic [31:0] rand_coord();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(4))
			0: return v;
			1: return {{12{v[19]}}, v[19:0]};
			2: return {{8{v[23]}}, v[23:0]};
			3: return v[0] ? MAXC : MINC;
			default: return {{16{v[15]}}, v[15:0]};
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (mismatches < 50) begin
			$display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		end
		mismatches++;
	endtask

	task automatic send_request(rot_req_t q, logic known, rot_res_t res);
		preset_q.push_back('{known, res});
		while ($urandom_range(99) < tx_idle) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {q.angle, q.z, q.y, q.x};
		s_axis_tuser  <= {q.three_d, q.axis};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		rot_req_t q;
		preset_t  p;
		rot_res_t want;
		rot_res_t got;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			q.x       = s_axis_tdata[31:0];
			q.y       = s_axis_tdata[63:32];
			q.z       = s_axis_tdata[95:64];
			q.angle   = s_axis_tdata[111:96];
			q.axis    = s_axis_tuser[1:0];
			q.three_d = s_axis_tuser[2];
			p = preset_q.pop_front();
			rotated_q.push_back(p.known ? p.res : rotate_vector(q));
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.x = m_axis_tdata[31:0];
			got.y = m_axis_tdata[63:32];
			got.z = m_axis_tdata[95:64];
			if (rotated_q.size() == 0) begin
				report_mismatch("unexpected result x", got.x, '0);
			end else begin
				want = rotated_q.pop_front();
				if (got.x !== want.x) begin
					report_mismatch("x_out", got.x, want.x);
				end
				if (got.y !== want.y) begin
					report_mismatch("y_out", got.y, want.y);
				end
				if (got.z !== want.z) begin
					report_mismatch("z_out", got.z, want.z);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_LEN) @(negedge clk);
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rx_idle);
			end
		end
	end

	initial begin
		rot_req_t q;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		tx_idle       = 16;
		rx_idle       = 73;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (DIRECTED[i]) begin
			send_request(DIRECTED[i].req, DIRECTED[i].known, DIRECTED[i].res);
		end

		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n == 250) begin
				tx_idle = 73;
				rx_idle = 16;
			end
			if (n == 500) begin
				tx_idle = 0;
				rx_idle = 0;
			end
			if (n == 300) begin
				s_axis_tvalid <= 1'b0;
				@(negedge clk);
				while (rotated_q.size() != 0) @(negedge clk);
			end
			if (n == 550) begin
				hold_req = 1'b1;
			end
			q.x       = rand_coord();
			q.y       = rand_coord();
			q.z       = rand_coord();
			q.angle   = ($urandom_range(7) == 0) ? {2'($urandom), 14'h0} : 16'($urandom);
			q.axis    = 2'($urandom_range(3));
			q.three_d = 1'($urandom);
			send_request(q, 1'b0, '0);
		end
		s_axis_tvalid <= 1'b0;

		while (rotated_q.size() != 0) @(negedge clk);
		repeat (DRAIN) @(posedge clk);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
